// ===== rtl/text_console_char_writer_defines.svh =====
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at each rising edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at each rising edge outside reset.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCW_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// Types, register indexes, character codes and helpers of the console writer.
package tcw_pkg;

    // Configuration register index.
    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_COLUMNS   = 2'd0;
    localparam t_cfg_index CFG_ROWS      = 2'd1;
    localparam t_cfg_index CFG_ATTRIBUTE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_COLUMNS   = 8'd80;
    localparam logic [7:0] RST_ROWS      = 8'd25;
    localparam logic [7:0] RST_ATTRIBUTE = 8'd7;

    // Command codes.
    localparam logic CMD_PUT_CHAR = 1'b0;
    localparam logic CMD_SET_POS  = 1'b1;

    // Character codes with special handling.
    localparam logic [7:0] CH_BACKSPACE  = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LINE_FEED  = 8'h0A;
    localparam logic [7:0] CH_CARRIAGE   = 8'h0D;
    localparam logic [7:0] CH_PRINT_LOW  = 8'h20;
    localparam logic [7:0] CH_PRINT_HIGH = 8'h7F;

    // Tab stops every eight columns.
    localparam int unsigned TAB_STOP = 8;
    localparam logic [8:0]  TAB_MASK = ~9'(TAB_STOP - 1);

    // A zero geometry value counts as one.
    function automatic logic [7:0] eff_size(input logic [7:0] size);
        return (size == 8'd0) ? 8'd1 : size;
    endfunction

    // Clamp a coordinate to the last cell below the limit.
    function automatic logic [7:0] clamp_to(input logic [7:0] v, input logic [7:0] limit);
        return (v >= limit) ? limit - 8'd1 : v;
    endfunction

endpackage

// ===== rtl/tcw_interfaces.sv =====
// Handshake channels of the console writer: input items, results, configuration writes.
interface tcw_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] pos_x;
    logic [7:0] pos_y;

    modport source(output valid, cmd, char_code, pos_x, pos_y, input ready);
    modport sink(input valid, cmd, char_code, pos_x, pos_y, output ready);
endinterface

interface tcw_result_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic [15:0] cursor_index;

    modport source(output valid, write_enable, write_address, write_data, cursor_index,
                   input ready);
    modport sink(input valid, write_enable, write_address, write_data, cursor_index,
                 output ready);
endinterface

interface tcw_cfg_if;
    logic                valid;
    logic                ready;
    tcw_pkg::t_cfg_index index;
    logic [7:0]          data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/text_console_char_writer.sv =====
// Top level of the text console character writer.
//
//  Port       Dir  Carries
//  ---------  ---  -------------------------------------------------------
//  i_item     in   cmd, char_code, pos_x, pos_y (put character / set cursor)
//  o_result   out  write_enable, write_address, write_data, cursor_index
//  i_cfg      in   register index and data (columns, rows, attribute)
//
// One item per cycle is sustained while o_result is ready; an item passes through
// the input register, then the result register. The cursor update and both
// cell-index products sit between those registers. A stalled result holds the
// result register, which stalls the input register and then the input channel;
// configuration writes are always taken.
// Synchronous active-low reset restores the geometry, attribute and cursor.
`include "text_console_char_writer_defines.svh"

module text_console_char_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tcw_item_if.sink            i_item,
    tcw_result_if.source        o_result,
    tcw_cfg_if.sink             i_cfg
);

    // Configuration registers.
    logic [7:0] r_columns;
    logic [7:0] r_rows;
    logic [7:0] r_attribute;

    // Input register.
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [7:0] r_in_char;
    logic [7:0] r_in_pos_x;
    logic [7:0] r_in_pos_y;

    // Cursor state.
    logic [7:0] r_col;
    logic [7:0] r_row;
    logic [7:0] n_col;
    logic [7:0] n_row;

    // Result register.
    logic        r_out_valid;
    logic        r_we;
    logic [15:0] r_addr;
    logic [15:0] r_data;
    logic [15:0] r_cursor;
    logic        n_we;
    logic [15:0] n_addr;
    logic [15:0] n_data;
    logic [15:0] n_cursor;

    // Pipeline control.
    logic w_advance;
    logic w_load_out;
    logic w_take_in;

    // Working values of the cursor update.
    logic [7:0] w_cols;
    logic [7:0] w_rows;
    logic [7:0] w_col0;
    logic [7:0] w_row0;
    logic [8:0] w_col_next;
    logic [8:0] w_row_inc;
    logic       w_new_line;

    assign w_advance  = !r_out_valid || o_result.ready;
    assign w_load_out = r_in_valid && w_advance;
    assign w_take_in  = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= tcw_pkg::RST_COLUMNS;
            r_rows      <= tcw_pkg::RST_ROWS;
            r_attribute <= tcw_pkg::RST_ATTRIBUTE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tcw_pkg::CFG_COLUMNS:   r_columns   <= i_cfg.data;
                tcw_pkg::CFG_ROWS:      r_rows      <= i_cfg.data;
                tcw_pkg::CFG_ATTRIBUTE: r_attribute <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input register: valid flag and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in_cmd   <= i_item.cmd;
            r_in_char  <= i_item.char_code;
            r_in_pos_x <= i_item.pos_x;
            r_in_pos_y <= i_item.pos_y;
        end
    end

    // Cursor update and result fields for the item in the input register.
    always_comb begin
        w_cols     = tcw_pkg::eff_size(r_columns);
        w_rows     = tcw_pkg::eff_size(r_rows);
        w_col0     = tcw_pkg::clamp_to(r_col, w_cols);
        w_row0     = tcw_pkg::clamp_to(r_row, w_rows);
        w_col_next = {1'b0, w_col0};
        w_row_inc  = {1'b0, w_row0} + 9'd1;
        w_new_line = 1'b0;
        n_we       = 1'b0;
        n_addr     = 16'd0;
        n_data     = 16'd0;
        n_col      = w_col0;
        n_row      = w_row0;

        if (r_in_cmd == tcw_pkg::CMD_SET_POS) begin
            n_col = tcw_pkg::clamp_to(r_in_pos_x, w_cols);
            n_row = tcw_pkg::clamp_to(r_in_pos_y, w_rows);
        end else begin
            if (r_in_char == tcw_pkg::CH_BACKSPACE) begin
                if (w_col0 != 8'd0) begin
                    w_col_next = {1'b0, w_col0} - 9'd1;
                end
            end else if (r_in_char == tcw_pkg::CH_TAB) begin
                w_col_next = ({1'b0, w_col0} + 9'(tcw_pkg::TAB_STOP)) & tcw_pkg::TAB_MASK;
            end else if (r_in_char == tcw_pkg::CH_CARRIAGE) begin
                w_col_next = 9'd0;
            end else if (r_in_char == tcw_pkg::CH_LINE_FEED) begin
                w_col_next = 9'd0;
                w_new_line = 1'b1;
            end else if (r_in_char >= tcw_pkg::CH_PRINT_LOW &&
                         r_in_char <= tcw_pkg::CH_PRINT_HIGH) begin
                n_we       = 1'b1;
                n_addr     = 16'(w_row0) * 16'(w_cols) + 16'(w_col0);
                n_data     = {r_attribute, r_in_char};
                w_col_next = {1'b0, w_col0} + 9'd1;
            end

            // Running off the right edge starts a new line.
            if (w_col_next >= {1'b0, w_cols}) begin
                w_col_next = 9'd0;
                w_new_line = 1'b1;
            end

            // Row wraps to the top at the bottom of the screen.
            if (w_new_line) begin
                n_row = (w_row_inc >= {1'b0, w_rows}) ? 8'd0 : w_row_inc[7:0];
            end
            n_col = w_col_next[7:0];
        end

        n_cursor = 16'(n_row) * 16'(w_cols) + 16'(n_col);
    end

    // Cursor state moves when an item passes into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
        end else if (w_load_out) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Result register: valid flag and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_we     <= n_we;
            r_addr   <= n_addr;
            r_data   <= n_data;
            r_cursor <= n_cursor;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.write_enable  = r_we;
    assign o_result.write_address = r_addr;
    assign o_result.write_data    = r_data;
    assign o_result.cursor_index  = r_cursor;

    // An item leaving the input register always shows up as a result.
    `TCW_ASSERT_NEXT(a_load_gives_result, i_clk, i_rst_n, w_load_out, r_out_valid,
                     "item lost between registers")

    // The stored column stays on the screen that was in force at the update.
    `TCW_ASSERT_NEXT(a_col_on_screen, i_clk, i_rst_n, w_load_out, r_col < $past(w_cols),
                     "cursor column off screen")

    // A cell write carries a printable character.
    `TCW_ASSERT(a_write_printable, i_clk, i_rst_n, r_out_valid && r_we,
                r_data[7:0] >= tcw_pkg::CH_PRINT_LOW && r_data[7] == 1'b0,
                "non-printable character written")

    // Results without a write carry zero address and data.
    `TCW_ASSERT(a_idle_fields_zero, i_clk, i_rst_n, r_out_valid && !r_we,
                r_addr == 16'd0 && r_data == 16'd0, "stray write fields")

endmodule
